// File: design/lsd_radix_sort_keys_macros.svh
// ----------------------------------------------------------------------------
// lsd radix sort assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef LSD_RADIX_SORT_KEYS_MACROS_SVH
`define LSD_RADIX_SORT_KEYS_MACROS_SVH

// implication checked on every clock edge outside reset
`define LRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication with the consequent checked in the next cycle
`define LRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lsd radix sort package
// widths and defaults shared by the sorter files
// ----------------------------------------------------------------------------
`default_nettype none
package lrs_pkg;
  localparam int unsigned MAX_ITEMS_DEF      = 64;
  localparam int unsigned MAX_DIGIT_BITS_DEF = 8;
  localparam int unsigned KEY_BITS_DEF       = 32;
  localparam int unsigned KEY_W              = 32;
  localparam int unsigned TAG_W              = 16;
  localparam int unsigned CFG_W              = 4;
  localparam logic [CFG_W-1:0] DIGIT_BITS_RST = 4'd4;
endpackage
`default_nettype wire

// File: design/lrs_in_if.sv
// ----------------------------------------------------------------------------
// lsd radix sort record channels
// valid/ready channels for loaded and sorted records
// ----------------------------------------------------------------------------
`default_nettype none
interface lrs_in_if
  import lrs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;
  logic [TAG_W-1:0] tag;
  logic             last_in;
  modport source (output valid, key, tag, last_in, input ready);
  modport sink   (input valid, key, tag, last_in, output ready);
endinterface

interface lrs_out_if
  import lrs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] sorted_key;
  logic [TAG_W-1:0] sorted_tag;
  logic             last_out;
  logic             overflow;
  modport source (output valid, sorted_key, sorted_tag, last_out, overflow, input ready);
  modport sink   (input valid, sorted_key, sorted_tag, last_out, overflow, output ready);
endinterface
`default_nettype wire

// File: design/lsd_radix_sort_keys.sv
// ----------------------------------------------------------------------------
// lsd radix sort of keyed records
// loads a set, sorts it by radix passes in memory, streams it out
// ----------------------------------------------------------------------------
// channel  dir  fields
// in       in   key, tag, last_in
// out      out  sorted_key, sorted_tag, last_out, overflow
// cfg      in   digit_bits (write only)
//
// load: one beat per cycle into the record memory
// sort: per pass clear 2^d bucket counters, count n keys, prefix-sum the buckets,
//   scatter n records and copy them back; passes = ceil(KEY_BITS/d)
// output: one beat per cycle while out is ready, through a registered output stage
// stalls: input closed from the last beat of a set until the sorted set drains
// reset: control only, memories hold no reset; bucket counters cleared per pass
// ----------------------------------------------------------------------------
`default_nettype none
module lsd_radix_sort_keys
  import lrs_pkg::*;
#(
  parameter int unsigned MAX_ITEMS      = MAX_ITEMS_DEF,
  parameter int unsigned MAX_DIGIT_BITS = MAX_DIGIT_BITS_DEF,
  parameter int unsigned KEY_BITS       = KEY_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  lrs_in_if.sink           in_ch,
  lrs_out_if.source        out_ch,
  input  wire              cfg_we,
  input  wire  [CFG_W-1:0] cfg_wdata
);
  localparam int unsigned AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned NB  = 1 << MAX_DIGIT_BITS;
  localparam int unsigned BW  = MAX_DIGIT_BITS;
  localparam int unsigned BCW = BW + 1;
  localparam int unsigned SW  = $clog2(KEY_BITS + MAX_DIGIT_BITS + 1);

  typedef enum logic [9:0] {
    S_LOAD  = 10'b0000000001,
    S_PASS  = 10'b0000000010,
    S_CLR   = 10'b0000000100,
    S_CNT   = 10'b0000001000,
    S_PRE   = 10'b0000010000,
    S_SCAT  = 10'b0000100000,
    S_COPY  = 10'b0001000000,
    S_OUT   = 10'b0010000000,
    S_DRAIN = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  logic [KEY_W-1:0] key_store   [MAX_ITEMS];
  logic [TAG_W-1:0] tag_store   [MAX_ITEMS];
  logic [KEY_W-1:0] key_scratch [MAX_ITEMS];
  logic [TAG_W-1:0] tag_scratch [MAX_ITEMS];
  logic [CW-1:0]    bucket_counts [NB];

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] digit_bits_r;
  logic [CW-1:0]    item_count_r;
  logic             overflow_r;
  logic [CW-1:0]    idx_r;
  logic [BCW-1:0]   bidx_r;
  logic [CW-1:0]    run_r;
  logic [SW-1:0]    shift_r;
  logic             rd_v_r;
  logic [BW-1:0]    rd_b_r;
  logic [CW-1:0]    rd_i_r;
  logic             wr_v_r;
  logic [KEY_W-1:0] wr_key_r;
  logic [TAG_W-1:0] wr_tag_r;
  logic [KEY_W-1:0] st_key_q;
  logic [TAG_W-1:0] st_tag_q;
  logic [KEY_W-1:0] sc_key_q;
  logic [TAG_W-1:0] sc_tag_q;
  logic [CW-1:0]    bc_q;
  logic             fwd_v_r;
  logic [BW-1:0]    fwd_b_r;
  logic [CW-1:0]    fwd_val_r;
  logic             ov_v_r;
  logic [KEY_W-1:0] ov_key_r;
  logic [TAG_W-1:0] ov_tag_r;
  logic             ov_last_r;
  logic             ov_ovf_r;

  logic [3:0]       dbits;
  logic [BW-1:0]    dmask;
  logic [BW-1:0]    st_digit;
  logic [CW-1:0]    bc_cur;
  logic             in_acc;
  logic             out_free;
  logic [AW-1:0]    idx_a;
  logic [AW-1:0]    rdi_a;

  always_comb begin
    dbits = digit_bits_r;
    if (dbits == 4'd0) dbits = 4'd1;
    if (32'(dbits) > MAX_DIGIT_BITS) dbits = 4'(MAX_DIGIT_BITS);
  end
  assign dmask    = BW'((BCW'(1) << dbits) - BCW'(1));
  assign st_digit = BW'(64'(st_key_q & KEY_W'((65'(1) << KEY_BITS) - 65'(1))) >> shift_r)
                    & dmask;
  assign bc_cur   = (fwd_v_r && fwd_b_r == rd_b_r) ? fwd_val_r : bc_q;
  // hold the read address on output back-pressure
  assign idx_a    = (state_r == S_OUT && !out_free) ? rdi_a : AW'(idx_r);
  assign rdi_a    = AW'(rd_i_r);
  assign out_free = !ov_v_r || out_ch.ready;

  assign in_ch.ready = (state_r == S_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = ov_v_r;
  assign out_ch.sorted_key = ov_key_r;
  assign out_ch.sorted_tag = ov_tag_r;
  assign out_ch.last_out   = ov_last_r;
  assign out_ch.overflow   = ov_ovf_r;

  // record and scratch memories, one registered read each
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && in_acc && item_count_r < CW'(MAX_ITEMS)) begin
      key_store[AW'(item_count_r)] <= in_ch.key;
      tag_store[AW'(item_count_r)] <= in_ch.tag;
    end else if (state_r == S_COPY && rd_v_r) begin
      key_store[rdi_a] <= sc_key_q;
      tag_store[rdi_a] <= sc_tag_q;
    end
    st_key_q <= key_store[idx_a];
    st_tag_q <= tag_store[idx_a];
    sc_key_q <= key_scratch[idx_a];
    sc_tag_q <= tag_scratch[idx_a];
    if (state_r == S_SCAT && wr_v_r) begin
      key_scratch[AW'(bc_cur)] <= wr_key_r;
      tag_scratch[AW'(bc_cur)] <= wr_tag_r;
    end
  end

  // bucket counter memory
  always_ff @(posedge clk) begin
    bc_q <= bucket_counts[(state_r == S_PRE) ? BW'(bidx_r) : st_digit];
    if (state_r == S_CLR) begin
      bucket_counts[BW'(bidx_r)] <= '0;
    end else if (state_r == S_PRE && rd_v_r) begin
      bucket_counts[rd_b_r] <= run_r;
    end else if ((state_r == S_CNT || state_r == S_SCAT) && wr_v_r) begin
      bucket_counts[rd_b_r] <= bc_cur + CW'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:  if (in_acc && in_ch.last_in) state_nxt = S_PASS;
      S_PASS:  state_nxt = (shift_r >= SW'(KEY_BITS)) ? S_OUT : S_CLR;
      S_CLR:   if (bidx_r == BCW'(dmask)) state_nxt = S_CNT;
      S_CNT:   if (idx_r >= item_count_r && !rd_v_r && !wr_v_r) state_nxt = S_PRE;
      S_PRE:   if (bidx_r > BCW'(dmask) && !rd_v_r) state_nxt = S_SCAT;
      S_SCAT:  if (idx_r >= item_count_r && !rd_v_r && !wr_v_r) state_nxt = S_COPY;
      S_COPY:  if (idx_r >= item_count_r && !rd_v_r && !wr_v_r) state_nxt = S_PASS;
      S_OUT:   if (idx_r >= item_count_r && !rd_v_r) state_nxt = S_DRAIN;
      S_DRAIN: if (out_free) state_nxt = S_DONE;
      S_DONE:  state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      digit_bits_r <= DIGIT_BITS_RST;
      item_count_r <= '0;
      overflow_r   <= 1'b0;
      idx_r        <= '0;
      bidx_r       <= '0;
      run_r        <= '0;
      shift_r      <= '0;
      rd_v_r       <= 1'b0;
      wr_v_r       <= 1'b0;
      fwd_v_r      <= 1'b0;
      ov_v_r       <= 1'b0;
    end else begin
      if (cfg_we) digit_bits_r <= cfg_wdata;
      state_r <= state_nxt;
      fwd_v_r <= 1'b0;
      if (ov_v_r && out_ch.ready) ov_v_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          shift_r <= '0;
          if (in_acc) begin
            if (item_count_r < CW'(MAX_ITEMS)) item_count_r <= item_count_r + CW'(1);
            else overflow_r <= 1'b1;
          end
        end
        S_PASS: begin
          bidx_r <= '0;
          idx_r  <= '0;
          rd_v_r <= 1'b0;
          wr_v_r <= 1'b0;
        end
        S_CLR: begin
          bidx_r <= bidx_r + BCW'(1);
          if (bidx_r == BCW'(dmask)) bidx_r <= '0;
        end
        S_CNT, S_SCAT, S_COPY: begin
          rd_v_r <= idx_r < item_count_r;
          rd_i_r <= idx_r;
          if (idx_r < item_count_r) idx_r <= idx_r + CW'(1);
          // second stage: bucket counter read back and updated (not updated in copy)
          rd_b_r   <= st_digit;
          wr_v_r   <= rd_v_r && state_r != S_COPY;
          wr_key_r <= st_key_q;
          wr_tag_r <= st_tag_q;
          if (wr_v_r) begin
            fwd_v_r   <= 1'b1;
            fwd_b_r   <= rd_b_r;
            fwd_val_r <= bc_cur + CW'(1);
          end
          if (state_nxt != state_r) begin
            idx_r  <= '0;
            rd_v_r <= 1'b0;
            wr_v_r <= 1'b0;
            bidx_r <= '0;
            run_r  <= '0;
            if (state_r == S_COPY) shift_r <= shift_r + SW'(dbits);
          end
        end
        S_PRE: begin
          rd_v_r <= bidx_r <= BCW'(dmask);
          rd_b_r <= BW'(bidx_r);
          if (bidx_r <= BCW'(dmask)) bidx_r <= bidx_r + BCW'(1);
          if (rd_v_r) run_r <= run_r + bc_q;
          if (state_nxt != state_r) idx_r <= '0;
        end
        S_OUT: begin
          if (out_free) begin
            rd_v_r <= idx_r < item_count_r;
            rd_i_r <= idx_r;
            if (idx_r < item_count_r) idx_r <= idx_r + CW'(1);
            if (rd_v_r) begin
              ov_v_r    <= 1'b1;
              ov_key_r  <= st_key_q;
              ov_tag_r  <= st_tag_q;
              ov_last_r <= (rd_i_r + CW'(1)) == item_count_r;
              ov_ovf_r  <= overflow_r;
            end
          end
        end
        S_DRAIN: ;
        S_DONE: begin
          item_count_r <= '0;
          overflow_r   <= 1'b0;
          idx_r        <= '0;
          rd_v_r       <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/lrs_checker.sv
// ----------------------------------------------------------------------------
// lsd radix sort port checker
// port level checks on the record channels
// ----------------------------------------------------------------------------
`default_nettype none
`include "lsd_radix_sort_keys_macros.svh"
module lrs_checker
  import lrs_pkg::*;
(
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire out_last
);
  `LRS_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input open during output")
  `LRS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "beat dropped")
  `LRS_ASSERT_NEXT(a_last_closes, clk, rst_n, out_valid && out_ready && out_last, !out_valid, "beat after last")
endmodule

bind lsd_radix_sort_keys lrs_checker u_lrs_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last_out)
);
`default_nettype wire
